// ===== hw/rtl/tct_pkg.sv =====
// Package for the task control table: codes, types and sizing constants.
`default_nettype none
package tct_pkg;
    localparam int unsigned SlotCountDef = 256;
    localparam logic [30:0] IdentLimit = 31'h7FFF_FFFF;

    typedef enum logic [3:0] {
        ACT_CLEAR    = 4'd0,
        ACT_REGISTER = 4'd1,
        ACT_RUN      = 4'd2,
        ACT_YIELD    = 4'd3,
        ACT_DORMANT  = 4'd4,
        ACT_WAIT     = 4'd5,
        ACT_WAKE     = 4'd6,
        ACT_BY_ID    = 4'd7,
        ACT_BY_INDEX = 4'd8,
        ACT_FIND     = 4'd9
    } t_action;

    typedef enum logic [2:0] {
        ST_UNUSED  = 3'd0,
        ST_DORMANT = 3'd1,
        ST_READY   = 3'd2,
        ST_RUNNING = 3'd3,
        ST_WAITING = 3'd4
    } t_slot_state;

    typedef enum logic [2:0] {
        RS_OK        = 3'd0,
        RS_INVALID   = 3'd1,
        RS_FULL      = 3'd2,
        RS_EXHAUSTED = 3'd3,
        RS_NOT_FOUND = 3'd4,
        RS_BAD_STATE = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        SQ_IDLE, SQ_CLEAR, SQ_SCAN, SQ_READ, SQ_WRITE, SQ_SUM, SQ_DONE
    } t_seq;

    // Scan match kinds for the shared compare unit
    typedef enum logic [1:0] {
        MK_FREE, MK_IDENT, MK_WAITER
    } t_match;

    // One slot record as it sits in the store
    typedef struct packed {
        logic [2:0]  state;
        logic [30:0] ident;
        logic [7:0]  prio;
        logic [15:0] wait_sem;
        logic [63:0] entry;
        logic [63:0] stk_base;
        logic [63:0] stk_size;
    } t_record;
endpackage
`default_nettype wire

// ===== hw/rtl/tct_store.sv =====
// Slot store: one memory of records, one write and one registered read port.
`default_nettype none
module tct_store #(
    parameter int unsigned SLOT_COUNT = tct_pkg::SlotCountDef,
    parameter int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire tct_pkg::t_record i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output tct_pkg::t_record     o_rdata
);
    import tct_pkg::*;

    t_record r_mem [SLOT_COUNT];

    // Write and read the record array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/tct_match.sv =====
// Shared compare unit: decides whether a record hits the current search.
`default_nettype none
module tct_match (
    input  wire tct_pkg::t_match  i_kind,
    input  wire tct_pkg::t_record i_rec,
    input  wire logic [30:0]      i_ident,
    input  wire logic [15:0]      i_sem,
    output logic                  o_hit
);
    import tct_pkg::*;

    // Compare one record against the key
    always_comb begin
        case (i_kind)
            MK_FREE:   o_hit = (i_rec.state == ST_UNUSED);
            MK_IDENT:  o_hit = (i_rec.state != ST_UNUSED) && (i_rec.ident == i_ident);
            MK_WAITER: o_hit = (i_rec.state == ST_WAITING) && (i_rec.wait_sem == i_sem);
            default:   o_hit = 1'b0;
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/task_control_table.sv =====
// Top level of the task control table: sequencer, id counter and result port.
// Invalid and unknown commands go straight to the result; lookup by index reads the
// given slot without a scan; scans go one slot per cycle through the single read
// port of the slot memory; clear sweeps every slot.
// busy stays high until the strobe cycle, so one item at a time; the receiver cannot stall.
// After reset a clearing pass over every slot runs with busy high.
`default_nettype none
module task_control_table #(
    parameter int unsigned SLOT_COUNT = tct_pkg::SlotCountDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  i_action,
    input  wire logic [30:0] i_task_ident,
    input  wire logic [15:0] i_sem_ident,
    input  wire logic [7:0]  i_prio_in,
    input  wire logic        i_name_present,
    input  wire logic [63:0] i_entry_in,
    input  wire logic [63:0] i_stk_base_in,
    input  wire logic [63:0] i_stk_size_in,
    input  wire logic [7:0]  i_slot_in,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [30:0]      o_task_out,
    output logic [7:0]       o_slot_out,
    output logic [2:0]       o_state_out,
    output logic [7:0]       o_prio_out,
    output logic [15:0]      o_wait_sem_out,
    output logic [63:0]      o_entry_out,
    output logic [63:0]      o_stk_base_out,
    output logic [63:0]      o_stk_size_out,
    output logic [63:0]      o_stk_top_out
);
    import tct_pkg::*;

    localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned CW = AW + 1;
    localparam logic [CW-1:0] LastIdx = CW'(SLOT_COUNT - 1);

    t_seq        r_seq, n_seq;
    logic [CW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_hit, n_hit;
    logic [30:0] r_next_id, n_next_id;
    t_action     r_act;
    logic [30:0] r_tid;
    logic [15:0] r_sem;
    logic [7:0]  r_prio;
    logic [63:0] r_entry, r_base, r_size;
    t_status     r_st, n_st;
    logic        r_rec_ok, n_rec_ok;
    t_record     r_rec, n_rec;
    t_match      r_kind;
    logic        r_vld, n_vld;
    logic        r_pend, n_pend;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    t_record     wdata, rdata;
    logic        hit;
    logic        go;

    assign go = start && !busy;

    tct_store #(.SLOT_COUNT(SLOT_COUNT), .AW(AW)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    tct_match u_match (
        .i_kind(r_kind), .i_rec(rdata), .i_ident(r_tid), .i_sem(r_sem), .o_hit(hit)
    );

    // Hold the command fields on acceptance
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_act   <= t_action'(i_action);
            r_tid   <= i_task_ident;
            r_sem   <= i_sem_ident;
            r_prio  <= i_prio_in;
            r_entry <= i_entry_in;
            r_base  <= i_stk_base_in;
            r_size  <= i_stk_size_in;
            case (t_action'(i_action))
                ACT_REGISTER: r_kind <= MK_FREE;
                ACT_WAKE, ACT_FIND: r_kind <= MK_WAITER;
                default: r_kind <= MK_IDENT;
            endcase
        end
        r_rec  <= n_rec;
        r_hit  <= n_hit;
        r_st   <= n_st;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq     <= SQ_CLEAR;
            r_idx     <= '0;
            r_next_id <= 31'd1;
            r_rec_ok  <= 1'b0;
            r_vld     <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_seq     <= n_seq;
            r_idx     <= n_idx;
            r_next_id <= n_next_id;
            r_rec_ok  <= n_rec_ok;
            r_vld     <= n_vld;
            r_pend    <= n_pend;
        end
    end

    assign busy = (r_seq != SQ_IDLE);
    assign raddr = (r_seq == SQ_READ) ? r_hit : r_idx[AW-1:0];

    // Sequence the command
    always_comb begin
        n_seq     = r_seq;
        n_idx     = r_idx;
        n_hit     = r_hit;
        n_next_id = r_next_id;
        n_st      = r_st;
        n_rec_ok  = r_rec_ok;
        n_rec     = r_rec;
        n_vld     = 1'b0;
        n_pend    = r_pend;
        we        = 1'b0;
        waddr     = r_hit;
        wdata     = r_rec;
        case (r_seq)
            SQ_IDLE: begin
                if (go) begin
                    n_idx    = '0;
                    n_rec_ok = 1'b0;
                    n_pend   = 1'b0;
                    n_st     = RS_OK;
                    n_seq    = SQ_DONE;
                    case (t_action'(i_action))
                        ACT_CLEAR: begin
                            n_seq = SQ_CLEAR;
                            n_pend = 1'b1;
                        end
                        ACT_REGISTER: begin
                            if (!i_name_present || i_entry_in == '0
                                || i_stk_base_in == '0 || i_stk_size_in == '0)
                                n_st = RS_INVALID;
                            else
                                n_seq = SQ_SCAN;
                        end
                        ACT_RUN, ACT_YIELD, ACT_DORMANT, ACT_BY_ID: begin
                            if (i_task_ident == '0) n_st = RS_INVALID;
                            else n_seq = SQ_SCAN;
                        end
                        ACT_WAIT: begin
                            if (i_task_ident == '0 || i_sem_ident == '0)
                                n_st = RS_INVALID;
                            else n_seq = SQ_SCAN;
                        end
                        ACT_WAKE, ACT_FIND: begin
                            if (i_sem_ident == '0) n_st = RS_INVALID;
                            else n_seq = SQ_SCAN;
                        end
                        ACT_BY_INDEX: begin
                            if (32'(i_slot_in) >= SLOT_COUNT) n_st = RS_NOT_FOUND;
                            else begin
                                n_hit = AW'(i_slot_in);
                                n_seq = SQ_READ;
                            end
                        end
                        default: n_st = RS_INVALID;
                    endcase
                end
            end
            SQ_CLEAR: begin
                // Sweep one slot per cycle back to the empty record
                we    = 1'b1;
                waddr = r_idx[AW-1:0];
                wdata = '0;
                n_next_id = 31'd1;
                if (r_idx == LastIdx) begin
                    n_idx = '0;
                    n_seq = r_pend ? SQ_DONE : SQ_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            SQ_SCAN: begin
                // Issue read of r_idx; compare the slot read last cycle
                n_idx = r_idx + 1'b1;
                if (r_pend && hit) begin
                    n_hit = AW'(r_idx - 1'b1);
                    n_seq = SQ_READ;
                end else if (r_pend && (r_idx - 1'b1) == LastIdx) begin
                    n_st  = (r_act == ACT_REGISTER) ? RS_FULL : RS_NOT_FOUND;
                    n_seq = SQ_DONE;
                end
                n_pend = 1'b1;
            end
            SQ_READ: begin
                // Address the hit slot; data arrives next cycle
                n_seq = SQ_WRITE;
            end
            SQ_WRITE: begin
                n_rec    = rdata;
                n_rec_ok = 1'b1;
                n_seq    = SQ_SUM;
                case (r_act)
                    ACT_REGISTER: begin
                        if (r_next_id == '0 || r_next_id >= IdentLimit) begin
                            n_st = RS_EXHAUSTED;
                            n_rec_ok = 1'b0;
                            n_seq = SQ_DONE;
                        end else begin
                            n_rec.state      = ST_READY;
                            n_rec.ident      = r_next_id;
                            n_rec.prio       = r_prio;
                            n_rec.wait_sem   = '0;
                            n_rec.entry      = r_entry;
                            n_rec.stk_base   = r_base;
                            n_rec.stk_size   = r_size;
                            n_next_id        = r_next_id + 31'd1;
                        end
                    end
                    ACT_RUN: begin
                        if (rdata.state == ST_READY) n_rec.state = ST_RUNNING;
                        else n_st = RS_BAD_STATE;
                    end
                    ACT_YIELD: begin
                        if (rdata.state == ST_RUNNING) n_rec.state = ST_READY;
                        else n_st = RS_BAD_STATE;
                    end
                    ACT_DORMANT: begin
                        if (rdata.state == ST_READY || rdata.state == ST_RUNNING)
                            n_rec.state = ST_DORMANT;
                        else n_st = RS_BAD_STATE;
                    end
                    ACT_WAIT: begin
                        if (rdata.state == ST_READY || rdata.state == ST_RUNNING) begin
                            n_rec.state = ST_WAITING;
                            n_rec.wait_sem = r_sem;
                        end else n_st = RS_BAD_STATE;
                    end
                    ACT_WAKE: begin
                        n_rec.state = ST_READY;
                        n_rec.wait_sem = '0;
                    end
                    default: ;
                endcase
            end
            SQ_SUM: begin
                // Commit the updated record
                we    = 1'b1;
                waddr = r_hit;
                wdata = r_rec;
                n_seq = SQ_DONE;
            end
            SQ_DONE: begin
                n_vld = 1'b1;
                n_pend = 1'b0;
                n_seq = SQ_IDLE;
            end
            default: n_seq = SQ_IDLE;
        endcase
    end

    // Drive the result from the held record
    always_ff @(posedge i_clk) begin
        if (r_seq == SQ_DONE) begin
            o_status         <= r_st;
            o_task_out       <= r_rec_ok ? r_rec.ident : '0;
            o_slot_out       <= r_rec_ok ? 8'(r_hit) : '0;
            o_state_out      <= r_rec_ok ? r_rec.state : '0;
            o_prio_out       <= r_rec_ok ? r_rec.prio : '0;
            o_wait_sem_out   <= r_rec_ok ? r_rec.wait_sem : '0;
            o_entry_out      <= r_rec_ok ? r_rec.entry : '0;
            o_stk_base_out   <= r_rec_ok ? r_rec.stk_base : '0;
            o_stk_size_out   <= r_rec_ok ? r_rec.stk_size : '0;
            o_stk_top_out    <= r_rec_ok ? (r_rec.stk_base + r_rec.stk_size) : '0;
        end
    end
    assign o_valid = r_vld;

`ifndef SYNTHESIS
    a_no_start_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("strobe while busy");
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SQ_DONE) |=> o_valid) else $error("missing strobe");
    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id != '0) else $error("id counter zero");
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> busy) else $error("write while idle");
`endif
endmodule
`default_nettype wire

// ===== test/task_control_table_tb.sv =====
// Testbench for the task control table: random and directed commands against a predictor.
`default_nettype none
module task_control_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tct_pkg::*;

    localparam int unsigned SLOTS = 256;

    typedef struct {
        logic [3:0]  action;
        logic [30:0] task_ident;
        logic [15:0] sem_ident;
        logic [7:0]  prio;
        logic        name_present;
        logic [63:0] entry;
        logic [63:0] stk_base;
        logic [63:0] stk_size;
        logic [7:0]  slot;
    } t_cmd;

    typedef struct {
        logic [2:0]  status;
        logic [30:0] task_id;
        logic [7:0]  slot;
        logic [2:0]  state;
        logic [7:0]  prio;
        logic [15:0] wait_sem;
        logic [63:0] entry;
        logic [63:0] stk_base;
        logic [63:0] stk_size;
        logic [63:0] stk_top;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  i_action = '0;
    logic [30:0] i_task_ident = '0;
    logic [15:0] i_sem_ident = '0;
    logic [7:0]  i_prio_in = '0;
    logic        i_name_present = 1'b0;
    logic [63:0] i_entry_in = '0;
    logic [63:0] i_stk_base_in = '0;
    logic [63:0] i_stk_size_in = '0;
    logic [7:0]  i_slot_in = '0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [30:0] o_task_out;
    logic [7:0]  o_slot_out;
    logic [2:0]  o_state_out;
    logic [7:0]  o_prio_out;
    logic [15:0] o_wait_sem_out;
    logic [63:0] o_entry_out;
    logic [63:0] o_stk_base_out;
    logic [63:0] o_stk_size_out;
    logic [63:0] o_stk_top_out;

    task_control_table dut (.*);

    // Predictor copy of the table
    t_slot_state tbl_state [SLOTS];
    logic [30:0] tbl_ident [SLOTS];
    logic [7:0]  tbl_prio [SLOTS];
    logic [15:0] tbl_sem [SLOTS];
    logic [63:0] tbl_entry [SLOTS];
    logic [63:0] tbl_base [SLOTS];
    logic [63:0] tbl_size [SLOTS];
    logic [30:0] ident_counter;

    t_cmd    pending_cmds [$];
    t_answer expected_answers [$];
    int      error_count = 0;
    int      idle_pct = 0;
    logic    taken = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void wipe_table();
        for (int s = 0; s < SLOTS; s++) begin
            tbl_state[s] = ST_UNUSED;
            tbl_ident[s] = '0;
            tbl_prio[s] = '0;
            tbl_sem[s] = '0;
            tbl_entry[s] = '0;
            tbl_base[s] = '0;
            tbl_size[s] = '0;
        end
        ident_counter = 31'd1;
    endfunction

    function automatic void fill_record(ref t_answer a, input int s);
        a.task_id = tbl_ident[s];
        a.slot = s[7:0];
        a.state = tbl_state[s];
        a.prio = tbl_prio[s];
        a.wait_sem = tbl_sem[s];
        a.entry = tbl_entry[s];
        a.stk_base = tbl_base[s];
        a.stk_size = tbl_size[s];
        a.stk_top = tbl_base[s] + tbl_size[s];
    endfunction

    function automatic int seek_id(logic [30:0] id);
        for (int s = 0; s < SLOTS; s++)
            if (tbl_state[s] != ST_UNUSED && tbl_ident[s] == id) return s;
        return -1;
    endfunction

    function automatic int seek_sem(logic [15:0] sem);
        for (int s = 0; s < SLOTS; s++)
            if (tbl_state[s] == ST_WAITING && tbl_sem[s] == sem) return s;
        return -1;
    endfunction

    // Apply one command to the table copy and compute its answer
    function automatic t_answer apply_command(t_cmd c);
        t_answer a;
        int s;
        bit ok;
        a = '{default: '0};
        case (c.action)
            ACT_CLEAR: begin
                wipe_table();
                a.status = RS_OK;
            end
            ACT_REGISTER: begin
                s = -1;
                for (int k = 0; k < SLOTS; k++)
                    if (s < 0 && tbl_state[k] == ST_UNUSED) s = k;
                if (!c.name_present || c.entry == 0 || c.stk_base == 0 || c.stk_size == 0)
                    a.status = RS_INVALID;
                else if (s < 0)
                    a.status = RS_FULL;
                else if (ident_counter == 0 || ident_counter >= IdentLimit)
                    a.status = RS_EXHAUSTED;
                else begin
                    tbl_ident[s] = ident_counter;
                    ident_counter++;
                    tbl_prio[s] = c.prio;
                    tbl_state[s] = ST_READY;
                    tbl_sem[s] = '0;
                    tbl_entry[s] = c.entry;
                    tbl_base[s] = c.stk_base;
                    tbl_size[s] = c.stk_size;
                    a.status = RS_OK;
                    fill_record(a, s);
                end
            end
            ACT_RUN, ACT_YIELD, ACT_DORMANT, ACT_WAIT: begin
                if (c.task_ident == 0 || (c.action == ACT_WAIT && c.sem_ident == 0))
                    a.status = RS_INVALID;
                else begin
                    s = seek_id(c.task_ident);
                    if (s < 0) a.status = RS_NOT_FOUND;
                    else begin
                        if (c.action == ACT_RUN) ok = tbl_state[s] == ST_READY;
                        else if (c.action == ACT_YIELD) ok = tbl_state[s] == ST_RUNNING;
                        else ok = tbl_state[s] == ST_READY || tbl_state[s] == ST_RUNNING;
                        if (!ok) a.status = RS_BAD_STATE;
                        else begin
                            case (c.action)
                                ACT_RUN: tbl_state[s] = ST_RUNNING;
                                ACT_YIELD: tbl_state[s] = ST_READY;
                                ACT_DORMANT: tbl_state[s] = ST_DORMANT;
                                default: begin
                                    tbl_state[s] = ST_WAITING;
                                    tbl_sem[s] = c.sem_ident;
                                end
                            endcase
                            a.status = RS_OK;
                        end
                        fill_record(a, s);
                    end
                end
            end
            ACT_WAKE, ACT_FIND: begin
                if (c.sem_ident == 0) a.status = RS_INVALID;
                else begin
                    s = seek_sem(c.sem_ident);
                    if (s < 0) a.status = RS_NOT_FOUND;
                    else begin
                        if (c.action == ACT_WAKE) begin
                            tbl_state[s] = ST_READY;
                            tbl_sem[s] = '0;
                        end
                        a.status = RS_OK;
                        fill_record(a, s);
                    end
                end
            end
            ACT_BY_ID: begin
                if (c.task_ident == 0) a.status = RS_INVALID;
                else begin
                    s = seek_id(c.task_ident);
                    if (s < 0) a.status = RS_NOT_FOUND;
                    else begin
                        a.status = RS_OK;
                        fill_record(a, s);
                    end
                end
            end
            ACT_BY_INDEX: begin
                a.status = RS_OK;
                fill_record(a, int'(c.slot));
            end
            default: a.status = RS_INVALID;
        endcase
        return a;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random command with content of a given action
    function automatic t_cmd make_cmd(logic [3:0] act);
        t_cmd c;
        c.action = act;
        // favor ids that have been handed out and a few semaphores
        case ($urandom_range(0, 9))
            0: c.task_ident = '0;
            1: c.task_ident = 31'($urandom());
            default: c.task_ident = 31'($urandom_range(1, 40));
        endcase
        case ($urandom_range(0, 9))
            0: c.sem_ident = '0;
            1: c.sem_ident = 16'($urandom());
            default: c.sem_ident = 16'($urandom_range(1, 4));
        endcase
        c.prio = 8'($urandom());
        c.name_present = $urandom_range(0, 15) != 0;
        c.entry = $urandom_range(0, 15) == 0 ? 64'd0 : rand64();
        c.stk_base = $urandom_range(0, 15) == 0 ? 64'd0 : rand64();
        c.stk_size = $urandom_range(0, 15) == 0 ? 64'd0 : rand64();
        c.slot = $urandom_range(0, 3) == 0 ? 8'($urandom()) : 8'($urandom_range(0, 12));
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Driver: present items at the falling edge, hold until accepted
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!start || taken) begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    t_cmd c;
                    c = pending_cmds.pop_front();
                    i_action <= c.action;
                    i_task_ident <= c.task_ident;
                    i_sem_ident <= c.sem_ident;
                    i_prio_in <= c.prio;
                    i_name_present <= c.name_present;
                    i_entry_in <= c.entry;
                    i_stk_base_in <= c.stk_base;
                    i_stk_size_in <= c.stk_size;
                    i_slot_in <= c.slot;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: accept items and results at the rising edge
    always @(posedge i_clk) begin
        t_cmd c;
        t_answer w;
        taken <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            c = '{i_action, i_task_ident, i_sem_ident, i_prio_in, i_name_present,
                  i_entry_in, i_stk_base_in, i_stk_size_in, i_slot_in};
            expected_answers.push_back(apply_command(c));
        end
        if (i_rst_n && o_valid) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_status), 64'd0);
            end else begin
                w = expected_answers.pop_front();
                if (o_status !== w.status)
                    report_mismatch("status", 64'(o_status), 64'(w.status));
                if (o_task_out !== w.task_id)
                    report_mismatch("task", 64'(o_task_out), 64'(w.task_id));
                if (o_slot_out !== w.slot)
                    report_mismatch("slot", 64'(o_slot_out), 64'(w.slot));
                if (o_state_out !== w.state)
                    report_mismatch("state", 64'(o_state_out), 64'(w.state));
                if (o_prio_out !== w.prio)
                    report_mismatch("prio", 64'(o_prio_out), 64'(w.prio));
                if (o_wait_sem_out !== w.wait_sem)
                    report_mismatch("wait_sem", 64'(o_wait_sem_out), 64'(w.wait_sem));
                if (o_entry_out !== w.entry) report_mismatch("entry", o_entry_out, w.entry);
                if (o_stk_base_out !== w.stk_base)
                    report_mismatch("stk_base", o_stk_base_out, w.stk_base);
                if (o_stk_size_out !== w.stk_size)
                    report_mismatch("stk_size", o_stk_size_out, w.stk_size);
                if (o_stk_top_out !== w.stk_top)
                    report_mismatch("stk_top", o_stk_top_out, w.stk_top);
            end
        end
    end

    // Queue a run of random commands, mostly well-formed lifecycles
    task automatic queue_random(int n);
        t_cmd c;
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 1) c = make_cmd(ACT_CLEAR);
            else if (pick < 25) c = make_cmd(ACT_REGISTER);
            else if (pick < 28) c = make_cmd(4'($urandom_range(10, 15)));
            else c = make_cmd(4'($urandom_range(ACT_RUN, ACT_FIND)));
            pending_cmds.push_back(c);
        end
    endtask

    // Stimulus
    initial begin
        t_cmd c;
        wipe_table();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every action, field extremes, special cases
        c = make_cmd(ACT_REGISTER);
        c.name_present = 1'b1; c.entry = '1; c.stk_base = '1; c.stk_size = '1;
        c.prio = 8'hFF;
        pending_cmds.push_back(c);
        c.entry = 64'd1; c.stk_base = 64'd1; c.stk_size = 64'd1; c.prio = '0;
        pending_cmds.push_back(c);
        c.name_present = 1'b0; pending_cmds.push_back(c);
        c.name_present = 1'b1; c.entry = 0; pending_cmds.push_back(c);
        c.entry = 1; c.stk_base = 0; pending_cmds.push_back(c);
        c.stk_base = 1; c.stk_size = 0; pending_cmds.push_back(c);
        c = make_cmd(ACT_RUN); c.task_ident = 31'd1; pending_cmds.push_back(c);
        c.action = ACT_RUN; pending_cmds.push_back(c);
        c.action = ACT_YIELD; pending_cmds.push_back(c);
        c.action = ACT_WAIT; c.sem_ident = 16'hFFFF; pending_cmds.push_back(c);
        c.sem_ident = 0; pending_cmds.push_back(c);
        c.action = ACT_FIND; c.sem_ident = 16'hFFFF; pending_cmds.push_back(c);
        c.action = ACT_WAKE; pending_cmds.push_back(c);
        c.action = ACT_WAKE; pending_cmds.push_back(c);
        c.action = ACT_DORMANT; c.task_ident = 31'd2; pending_cmds.push_back(c);
        c.action = ACT_DORMANT; pending_cmds.push_back(c);
        c.action = ACT_BY_ID; c.task_ident = 31'h7FFF_FFFF; pending_cmds.push_back(c);
        c.task_ident = 0; pending_cmds.push_back(c);
        c.action = ACT_BY_INDEX; c.slot = 8'hFF; pending_cmds.push_back(c);
        c.slot = 8'd0; pending_cmds.push_back(c);
        c.action = 4'hF; pending_cmds.push_back(c);
        c.action = ACT_CLEAR; pending_cmds.push_back(c);
        c.action = ACT_BY_INDEX; pending_cmds.push_back(c);

        // phases of idling; the last phase fills the table to full
        idle_pct = 0;  queue_random(250);
        while (pending_cmds.size() > 0) @(posedge i_clk);
        idle_pct = 46; queue_random(250);
        while (pending_cmds.size() > 0) @(posedge i_clk);
        idle_pct = 15; queue_random(200);
        while (pending_cmds.size() > 0) @(posedge i_clk);
        idle_pct = 0;
        c = make_cmd(ACT_REGISTER);
        for (int k = 0; k < 262; k++) begin
            c.name_present = 1'b1; c.entry = rand64() | 64'd1;
            c.stk_base = rand64() | 64'd1;
            c.stk_size = rand64() | 64'd1;
            pending_cmds.push_back(c);
        end
        queue_random(60);
        while (pending_cmds.size() > 0) @(posedge i_clk);
        while (start || busy || expected_answers.size() > 0) @(posedge i_clk);
        repeat (SLOTS + 20) @(posedge i_clk);
        if (error_count == 0 && expected_answers.size() == 0)
            $display("task_control_table_tb: done, clean");
        else
            $display("task_control_table_tb: done, errors");
        $finish;
    end

    // Run limit
    initial begin
        #(1200 * 270 * 4 * 3);
        $display("task_control_table_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
